@@ sv/great_circle_distance_top_assert.svh @@
// Assertion macros shared by the great-circle distance RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
// Checked at every clock edge out of reset.
`define GCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define GCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ sv/gcd_pkg.sv @@
// Package for the great-circle distance block: limits, fixed-point constants,
// the pipeline tag type and elaboration-time table functions. No dependencies.
package gcd_pkg;

  localparam int unsigned ANGLE_FRACTION_BITS_DEF = 30;

  localparam int LAT_LIMIT = 90000;
  localparam int LON_LIMIT = 180000;

  localparam logic [24:0] MAX_DISTANCE = 25'd20037509;
  localparam logic [22:0] RADIUS_M     = 23'd6378137;

  // millidegree to radian factor, 52 fraction bits, round to nearest
  localparam int unsigned CONV_FRAC  = 52;
  localparam int unsigned CONV_WIDTH = 37;
  localparam logic [127:0] CONV_NUM  = (128'd314159 << CONV_FRAC) + 128'd9000000000;
  localparam logic [CONV_WIDTH-1:0] CONV_FACTOR = CONV_WIDTH'(CONV_NUM / 128'd18000000000);

  localparam logic [63:0] GAIN_Q62       = 64'd2800459870029452954;
  localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_HALF_Q62    = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic valid;
    logic err;
  } gcd_tag_t;

  // Q62 to f fraction bits, round to nearest
  function automatic logic [63:0] from_q62(input logic [63:0] a, input int unsigned f);
    return (a + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  // shift-subtract division, constants only
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q62 by the alternating series
  function automatic logic [63:0] atan_q62(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned sh;
    sum = '0;
    if (i == 0) return PI_QUARTER_Q62;
    for (int unsigned k = 0; k < 63; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 62) begin
        term = const_udiv(64'd1 << (62 - sh), 64'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

endpackage

@@ sv/gcd_smul.sv @@
// Registered signed fixed-point multiply, round half away from zero.
// Depends on gcd_pkg.
module gcd_smul #(
  parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic signed [ANGLE_FRACTION_BITS+3:0] a_i,
  input  logic signed [ANGLE_FRACTION_BITS+3:0] b_i,
  output logic signed [ANGLE_FRACTION_BITS+3:0] p_o
);
  import gcd_pkg::*;

  localparam int unsigned F  = ANGLE_FRACTION_BITS;
  localparam int unsigned W  = F + 4;
  localparam int unsigned PW = 2 * W;

  logic [W-1:0]  mag_a, mag_b, mag_p;
  logic [PW-1:0] prod;
  logic          neg;
  logic signed [W-1:0] p_d, p_q;

  always_comb begin
    neg   = a_i[W-1] ^ b_i[W-1];
    mag_a = a_i[W-1] ? W'(-a_i) : W'(a_i);
    mag_b = b_i[W-1] ? W'(-b_i) : W'(b_i);
    prod  = PW'(mag_a) * PW'(mag_b) + (PW'(1) << (F - 1));
    mag_p = W'(prod >> F);
    p_d   = neg ? -$signed(mag_p) : $signed(mag_p);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;
endmodule

@@ sv/gcd_sincos.sv @@
// Unrolled rotation-mode CORDIC, three angle lanes, one stage per iteration.
// Depends on gcd_pkg.
module gcd_sincos #(
  parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF,
  parameter int unsigned SIDE_WIDTH          = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gcd_pkg::gcd_tag_t                     tag_i,
  input  logic [SIDE_WIDTH-1:0]                 side_i,
  input  logic signed [ANGLE_FRACTION_BITS+3:0] z_i   [3],
  output gcd_pkg::gcd_tag_t                     tag_o,
  output logic [SIDE_WIDTH-1:0]                 side_o,
  output logic signed [ANGLE_FRACTION_BITS+3:0] cos_o [3],
  output logic signed [ANGLE_FRACTION_BITS+3:0] sin_o [3]
);
  import gcd_pkg::*;

  localparam int unsigned F = ANGLE_FRACTION_BITS;
  localparam int unsigned W = F + 4;
  localparam logic signed [W-1:0] GAIN = W'(from_q62(GAIN_Q62, F));

  logic signed [W-1:0] x_q [F][3];
  logic signed [W-1:0] y_q [F][3];
  logic signed [W-1:0] z_q [F][3];
  gcd_tag_t            tag_q [F];
  logic [SIDE_WIDTH-1:0] side_q [F];

  for (genvar i = 0; i < F; i++) begin : g_stage
    localparam logic signed [W-1:0] ATAN = W'(from_q62(atan_q62(i), F));
    logic signed [W-1:0] x_p [3], y_p [3], z_p [3];
    logic signed [W-1:0] x_d [3], y_d [3], z_d [3];
    gcd_tag_t              tag_p;
    logic [SIDE_WIDTH-1:0] side_p;

    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          x_p[l] = GAIN;
          y_p[l] = '0;
          z_p[l] = z_i[l];
        end
        tag_p  = tag_i;
        side_p = side_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          x_p[l] = x_q[i-1][l];
          y_p[l] = y_q[i-1][l];
          z_p[l] = z_q[i-1][l];
        end
        tag_p  = tag_q[i-1];
        side_p = side_q[i-1];
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (z_p[l] >= 0) begin
          x_d[l] = x_p[l] - (y_p[l] >>> i);
          y_d[l] = y_p[l] + (x_p[l] >>> i);
          z_d[l] = z_p[l] - ATAN;
        end else begin
          x_d[l] = x_p[l] + (y_p[l] >>> i);
          y_d[l] = y_p[l] - (x_p[l] >>> i);
          z_d[l] = z_p[l] + ATAN;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) tag_q[i] <= '0;
      else tag_q[i] <= tag_p;
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        x_q[i][l] <= x_d[l];
        y_q[i][l] <= y_d[l];
        z_q[i][l] <= z_d[l];
      end
      side_q[i] <= side_p;
    end
  end

  assign tag_o  = tag_q[F-1];
  assign side_o = side_q[F-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cos_o[l] = x_q[F-1][l];
      sin_o[l] = y_q[F-1][l];
    end
  end
endmodule

@@ sv/gcd_isqrt.sv @@
// Pipelined digit-by-digit integer square root of t * 2^F, one root bit a stage.
// Depends on gcd_pkg.
module gcd_isqrt #(
  parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF,
  parameter int unsigned SIDE_WIDTH          = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gcd_pkg::gcd_tag_t              tag_i,
  input  logic [SIDE_WIDTH-1:0]          side_i,
  input  logic [ANGLE_FRACTION_BITS+3:0] t_i,
  output gcd_pkg::gcd_tag_t              tag_o,
  output logic [SIDE_WIDTH-1:0]          side_o,
  output logic [ANGLE_FRACTION_BITS:0]   root_o
);
  import gcd_pkg::*;

  localparam int unsigned F    = ANGLE_FRACTION_BITS;
  localparam int unsigned NP   = F + 1;
  localparam int unsigned RW   = NP + 2;
  localparam int unsigned RADW = 2 * NP;

  logic [RW-1:0]         rem_q  [NP];
  logic [NP-1:0]         root_q [NP];
  logic [RADW-1:0]       rad_q  [NP];
  gcd_tag_t              tag_q  [NP];
  logic [SIDE_WIDTH-1:0] side_q [NP];

  for (genvar j = 0; j < NP; j++) begin : g_stage
    localparam int unsigned K = NP - 1 - j;
    logic [RW-1:0]         rem_p, rem_s, trial, rem_d;
    logic [NP-1:0]         root_p, root_d;
    logic [RADW-1:0]       rad_p;
    gcd_tag_t              tag_p;
    logic [SIDE_WIDTH-1:0] side_p;

    if (j == 0) begin : g_first
      always_comb begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = RADW'(t_i) << F;
        tag_p  = tag_i;
        side_p = side_i;
      end
    end else begin : g_next
      always_comb begin
        rem_p  = rem_q[j-1];
        root_p = root_q[j-1];
        rad_p  = rad_q[j-1];
        tag_p  = tag_q[j-1];
        side_p = side_q[j-1];
      end
    end

    always_comb begin
      rem_s = {rem_p[RW-3:0], rad_p[2*K+1 -: 2]};
      trial = {root_p, 2'b01};
      if (rem_s >= trial) begin
        rem_d  = rem_s - trial;
        root_d = {root_p[NP-2:0], 1'b1};
      end else begin
        rem_d  = rem_s;
        root_d = {root_p[NP-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) tag_q[j] <= '0;
      else tag_q[j] <= tag_p;
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= rem_d;
      root_q[j] <= root_d;
      rad_q[j]  <= rad_p;
      side_q[j] <= side_p;
    end
  end

  assign tag_o  = tag_q[NP-1];
  assign side_o = side_q[NP-1];
  assign root_o = root_q[NP-1];
endmodule

@@ sv/gcd_acos_cordic.sv @@
// acos by vectoring-mode CORDIC: quadrant pre-rotation, F iterations, clamp.
// Depends on gcd_pkg.
module gcd_acos_cordic #(
  parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gcd_pkg::gcd_tag_t                     tag_i,
  input  logic signed [ANGLE_FRACTION_BITS+3:0] a_i,
  input  logic [ANGLE_FRACTION_BITS:0]          root_i,
  output gcd_pkg::gcd_tag_t                     tag_o,
  output logic [ANGLE_FRACTION_BITS+3:0]        ang_o
);
  import gcd_pkg::*;

  localparam int unsigned F = ANGLE_FRACTION_BITS;
  localparam int unsigned W = F + 4;
  localparam logic signed [W-1:0] HALF_PI = W'(from_q62(PI_HALF_Q62, F));

  logic signed [W-1:0] x_q [F+1];
  logic signed [W-1:0] y_q [F+1];
  logic signed [W-1:0] z_q [F+1];
  gcd_tag_t            tag_q [F+1];
  logic signed [W-1:0] root_ext;
  logic signed [W-1:0] x0_d, y0_d, z0_d;
  logic [W-1:0]        ang_q;
  gcd_tag_t            tag_out_q;

  // left half-plane: rotate by a quarter turn first
  always_comb begin
    root_ext = W'(root_i);
    if (a_i < 0) begin
      x0_d = root_ext;
      y0_d = -a_i;
      z0_d = HALF_PI;
    end else begin
      x0_d = a_i;
      y0_d = root_ext;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_q[0] <= '0;
    else tag_q[0] <= tag_i;
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x0_d;
    y_q[0] <= y0_d;
    z_q[0] <= z0_d;
  end

  for (genvar i = 0; i < F; i++) begin : g_stage
    localparam logic signed [W-1:0] ATAN = W'(from_q62(atan_q62(i), F));
    logic signed [W-1:0] x_d, y_d, z_d;

    always_comb begin
      if (y_q[i] > 0) begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + ATAN;
      end else begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) tag_q[i+1] <= '0;
      else tag_q[i+1] <= tag_q[i];
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1] <= x_d;
      y_q[i+1] <= y_d;
      z_q[i+1] <= z_d;
    end
  end

  // rounding can leave a tiny negative angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_out_q <= '0;
    else tag_out_q <= tag_q[F];
  end

  always_ff @(posedge clk_i) begin
    ang_q <= (z_q[F] < 0) ? '0 : W'(z_q[F]);
  end

  assign tag_o = tag_out_q;
  assign ang_o = ang_q;
endmodule

@@ sv/great_circle_distance_top.sv @@
// Top level of the great-circle distance pipeline.
// Depends on gcd_pkg, gcd_smul, gcd_sincos, gcd_isqrt, gcd_acos_cordic and the
// assertion header great_circle_distance_top_assert.svh.
//
// Usage
//   Input: two points as signed millidegrees. A transfer happens at a rising
//   edge with start high and busy low; busy is always low, so a new point
//   pair can enter in every cycle.
//   Output: result_valid_o is high for exactly one cycle per transfer, with
//   distance_metres_o (rounded metres, saturated at half circumference) and
//   range_error_o. An out-of-range coordinate gives range_error_o = 1 and a
//   distance of zero. The receiver cannot stall; results leave in order.
//   Pipeline depth is set by the two unrolled CORDIC chains (one stage per
//   iteration) and the square root pipeline (one root bit per stage).
//   Throughput: one pair per cycle.
//   Reset: rst_ni clears every valid flag at once; no results come out until
//   new transfers have travelled the whole pipeline.
`include "great_circle_distance_top_assert.svh"

module great_circle_distance_top #(
  parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [17:0] first_latitude_i,
  input  logic signed [18:0] first_longitude_i,
  input  logic signed [17:0] second_latitude_i,
  input  logic signed [18:0] second_longitude_i,
  output logic               result_valid_o,
  output logic [24:0]        distance_metres_o,
  output logic               range_error_o
);
  import gcd_pkg::*;

  localparam int unsigned F  = ANGLE_FRACTION_BITS;
  localparam int unsigned W  = F + 4;
  localparam int unsigned NP = F + 1;
  localparam int unsigned PW = 18 + CONV_WIDTH;
  localparam int unsigned DW = W + 23;
  localparam logic signed [W-1:0] ONE       = W'(64'd1 << F);
  localparam logic [PW-1:0]       RAD_ROUND = PW'(64'd1 << (CONV_FRAC - 1 - F));

  assign busy = 1'b0;

  // ---- stage 1: range check, longitude difference folded to 0..90000
  logic               in_err;
  logic signed [19:0] dlon_raw;
  logic [19:0]        dlon_abs, dlon_wrap;
  logic [16:0]        dlon_fold;
  logic               fold_flip;

  always_comb begin
    in_err = (first_latitude_i < -LAT_LIMIT) || (first_latitude_i > LAT_LIMIT) ||
             (second_latitude_i < -LAT_LIMIT) || (second_latitude_i > LAT_LIMIT) ||
             (first_longitude_i < -LON_LIMIT) || (first_longitude_i > LON_LIMIT) ||
             (second_longitude_i < -LON_LIMIT) || (second_longitude_i > LON_LIMIT);
    dlon_raw  = 20'(second_longitude_i) - 20'(first_longitude_i);
    dlon_abs  = dlon_raw[19] ? 20'(-dlon_raw) : 20'(dlon_raw);
    // cos has period of a full turn and is even
    dlon_wrap = (dlon_abs > 20'(LON_LIMIT)) ? 20'(2 * LON_LIMIT) - dlon_abs : dlon_abs;
    // beyond a quarter turn: cos(180 - d) = -cos(d)
    if (dlon_wrap > 20'(LAT_LIMIT)) begin
      dlon_fold = 17'(20'(LON_LIMIT) - dlon_wrap);
      fold_flip = 1'b1;
    end else begin
      dlon_fold = 17'(dlon_wrap);
      fold_flip = 1'b0;
    end
  end

  logic signed [17:0] lat1_q, lat2_q;
  logic [16:0]        dlon_q;
  logic               flip1_q;
  gcd_tag_t           tag1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag1_q <= '0;
    else tag1_q <= '{valid: start && !busy, err: in_err};
  end

  always_ff @(posedge clk_i) begin
    lat1_q  <= first_latitude_i;
    lat2_q  <= second_latitude_i;
    dlon_q  <= dlon_fold;
    flip1_q <= fold_flip;
  end

  // ---- stage 2: magnitude times the radian factor
  logic [17:0]   mag1 [3];
  logic [PW-1:0] prod2_q [3];
  logic          sign2_q [3];
  logic          flip2_q;
  gcd_tag_t      tag2_q;

  always_comb begin
    mag1[0] = lat1_q[17] ? 18'(-lat1_q) : 18'(lat1_q);
    mag1[1] = lat2_q[17] ? 18'(-lat2_q) : 18'(lat2_q);
    mag1[2] = 18'(dlon_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag2_q <= '0;
    else tag2_q <= tag1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      prod2_q[l] <= PW'(mag1[l]) * PW'(CONV_FACTOR);
    end
    sign2_q[0] <= lat1_q[17];
    sign2_q[1] <= lat2_q[17];
    sign2_q[2] <= 1'b0;
    flip2_q    <= flip1_q;
  end

  // ---- stage 3: round to F fraction bits and restore the sign
  logic [PW-1:0]       rnd [3];
  logic signed [W-1:0] rmag [3];
  logic signed [W-1:0] rad_q [3];
  logic                flip3_q;
  gcd_tag_t            tag3_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l]  = (prod2_q[l] + RAD_ROUND) >> (CONV_FRAC - F);
      rmag[l] = W'(rnd[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag3_q <= '0;
    else tag3_q <= tag2_q;
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      rad_q[l] <= sign2_q[l] ? -rmag[l] : rmag[l];
    end
    flip3_q <= flip2_q;
  end

  // ---- sin and cos of both latitudes and the longitude difference
  logic signed [W-1:0] cos_w [3];
  logic signed [W-1:0] sin_w [3];
  gcd_tag_t            cs_tag;
  logic                cs_flip;

  gcd_sincos #(
    .ANGLE_FRACTION_BITS(F),
    .SIDE_WIDTH         (1)
  ) u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag3_q),
    .side_i (flip3_q),
    .z_i    (rad_q),
    .tag_o  (cs_tag),
    .side_o (cs_flip),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  // ---- P1: s1*s2 and c1*c2
  logic signed [W-1:0] s12_w, c12_w, cdf_q;
  gcd_tag_t            tagp1_q;

  gcd_smul #(.ANGLE_FRACTION_BITS(F)) u_mul_s12 (
    .clk_i (clk_i), .a_i (sin_w[0]), .b_i (sin_w[1]), .p_o (s12_w)
  );
  gcd_smul #(.ANGLE_FRACTION_BITS(F)) u_mul_c12 (
    .clk_i (clk_i), .a_i (cos_w[0]), .b_i (cos_w[1]), .p_o (c12_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tagp1_q <= '0;
    else tagp1_q <= cs_tag;
  end

  always_ff @(posedge clk_i) begin
    cdf_q <= cs_flip ? -cos_w[2] : cos_w[2];
  end

  // ---- P2: c1*c2*cos(dlon)
  logic signed [W-1:0] cc_w, s12_q;
  gcd_tag_t            tagp2_q;

  gcd_smul #(.ANGLE_FRACTION_BITS(F)) u_mul_cc (
    .clk_i (clk_i), .a_i (c12_w), .b_i (cdf_q), .p_o (cc_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tagp2_q <= '0;
    else tagp2_q <= tagp1_q;
  end

  always_ff @(posedge clk_i) begin
    s12_q <= s12_w;
  end

  // ---- P3: sum, clamp to [-1, 1]
  logic signed [W:0]   arg_sum;
  logic signed [W-1:0] arg_d, arg_q;
  gcd_tag_t            tagp3_q;

  always_comb begin
    arg_sum = (W+1)'(s12_q) + (W+1)'(cc_w);
    if (arg_sum > (W+1)'(ONE)) arg_d = ONE;
    else if (arg_sum < -(W+1)'(ONE)) arg_d = -ONE;
    else arg_d = W'(arg_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tagp3_q <= '0;
    else tagp3_q <= tagp2_q;
  end

  always_ff @(posedge clk_i) begin
    arg_q <= arg_d;
  end

  // ---- P4: (1 - a)(1 + a) for the sine of the angle
  logic signed [W-1:0] om, op, t_w, arg4_q;
  gcd_tag_t            tagp4_q;

  assign om = ONE - arg_q;
  assign op = ONE + arg_q;

  gcd_smul #(.ANGLE_FRACTION_BITS(F)) u_mul_t (
    .clk_i (clk_i), .a_i (om), .b_i (op), .p_o (t_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tagp4_q <= '0;
    else tagp4_q <= tagp3_q;
  end

  always_ff @(posedge clk_i) begin
    arg4_q <= arg_q;
  end

  // ---- square root, cosine argument rides along
  logic [NP-1:0] root_w;
  logic [W-1:0]  a_side;
  gcd_tag_t      sq_tag;

  gcd_isqrt #(
    .ANGLE_FRACTION_BITS(F),
    .SIDE_WIDTH         (W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tagp4_q),
    .side_i (W'(arg4_q)),
    .t_i    (W'(t_w)),
    .tag_o  (sq_tag),
    .side_o (a_side),
    .root_o (root_w)
  );

  // ---- arc cosine
  logic [W-1:0] ang_w;
  gcd_tag_t     ac_tag;

  gcd_acos_cordic #(.ANGLE_FRACTION_BITS(F)) u_acos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (sq_tag),
    .a_i    ($signed(a_side)),
    .root_i (root_w),
    .tag_o  (ac_tag),
    .ang_o  (ang_w)
  );

  // ---- angle times radius, rounded to metres
  logic [DW-1:0]   dprod;
  logic [DW-F-1:0] dist_q;
  gcd_tag_t        tagd_q;

  assign dprod = DW'(ang_w) * DW'(RADIUS_M) + (DW'(1) << (F - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tagd_q <= '0;
    else tagd_q <= ac_tag;
  end

  always_ff @(posedge clk_i) begin
    dist_q <= (DW-F)'(dprod >> F);
  end

  // ---- output register: saturate, zero on range error
  logic [24:0] dist_d;

  always_comb begin
    if (tagd_q.err) dist_d = '0;
    else if (dist_q > (DW-F)'(MAX_DISTANCE)) dist_d = MAX_DISTANCE;
    else dist_d = 25'(dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= tagd_q.valid;
  end

  always_ff @(posedge clk_i) begin
    distance_metres_o <= dist_d;
    range_error_o     <= tagd_q.err;
  end

  // ---- checks
  `GCD_ASSERT(a_err_zero, clk_i, rst_ni, result_valid_o && range_error_o |-> distance_metres_o == 25'd0, "range error with nonzero distance")
  `GCD_ASSERT(a_dist_max, clk_i, rst_ni, result_valid_o |-> distance_metres_o <= MAX_DISTANCE, "distance above half circumference")
  `GCD_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !result_valid_o, "result strobe during reset")
endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for great_circle_distance_top: drives point pairs,
// predicts distances with a fixed-point law-of-cosines model, checks results.
// Depends on gcd_pkg and the great_circle_distance_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import gcd_pkg::*;

  localparam int F = 30;             // angle fraction bits, matches DUT default
  localparam int PIPE_LATENCY = 3 * F + 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 410;  // per idling phase

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic [24:0] distance;
    logic        range_err;
  } distance_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [17:0] first_latitude_i;
  logic signed [18:0] first_longitude_i;
  logic signed [17:0] second_latitude_i;
  logic signed [18:0] second_longitude_i;
  logic               result_valid_o;
  logic [24:0]        distance_metres_o;
  logic               range_error_o;

  great_circle_distance_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .first_latitude_i   (first_latitude_i),
    .first_longitude_i  (first_longitude_i),
    .second_latitude_i  (second_latitude_i),
    .second_longitude_i (second_longitude_i),
    .result_valid_o     (result_valid_o),
    .distance_metres_o  (distance_metres_o),
    .range_error_o      (range_error_o)
  );

  // Distances still in flight, oldest first.
  distance_t pending_distances[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  longint unsigned arctan_steps[F];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point distance predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // (a*b + half) >> s, full-width product
  function automatic longint unsigned rnd_mul_shift(longint unsigned a, longint unsigned b,
                                                    int s);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    p = p + (wide_t'(1) << (s - 1));
    return 64'(p >> s);
  endfunction

  // signed Q product, rounding half away from zero
  function automatic longint q_mul(longint a, longint b);
    longint unsigned r;
    r = rnd_mul_shift(magnitude(a), magnitude(b), F);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned narrow_q62(longint unsigned a);
    return (a + (64'd1 << (61 - F))) >> (62 - F);
  endfunction

  // atan(2^-i) in Q62 from its power series
  function automatic longint unsigned arctan_pow2(int i);
    longint sum;
    longint unsigned term;
    int sh;
    sum = 0;
    if (i == 0) return PI_QUARTER_Q62;
    for (int k = 0; k < 63; k++) begin
      sh = i * (2 * k + 1);
      if (sh > 62) break;
      term = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
      if (k % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    return longint'(sum);
  endfunction

  // millidegrees to Q radians through a 52-bit factor
  function automatic longint to_rad(longint mdeg);
    wide_t factor;
    longint unsigned r;
    factor = ((wide_t'(314159) << 52) + wide_t'(64'd9000000000)) / wide_t'(64'd18000000000);
    r = magnitude(mdeg) * 64'(factor);
    r = (r + (64'd1 << (52 - 1 - F))) >> (52 - F);
    return mdeg < 0 ? -longint'(r) : longint'(r);
  endfunction

  // CORDIC rotation: cos and sin of z
  function automatic void rotate_angle(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = longint'(narrow_q62(GAIN_Q62));
    y = 0;
    for (int i = 0; i < F; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arctan_steps[i]);
      end else begin
        x += dx; y -= dy; z += longint'(arctan_steps[i]);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint unsigned root_of(wide_t v);
    wide_t r, rem, trial;
    r = 0;
    rem = 0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & wide_t'(3));
      trial = (r << 2) | wide_t'(1);
      if (rem >= trial) begin
        rem -= trial; r = (r << 1) | wide_t'(1);
      end else begin
        r = r << 1;
      end
    end
    return 64'(r);
  endfunction

  // acos via sqrt(1-a^2) then CORDIC vectoring; negative leftovers clip to zero
  function automatic longint arc_cosine(longint a);
    longint one, x, y, z, dx, dy, keep;
    longint unsigned t;
    one = longint'(64'd1 << F);
    t = longint'(q_mul(one - a, one + a));
    x = a;
    y = longint'(root_of(wide_t'(t) << F));
    z = 0;
    if (x < 0) begin
      keep = y; y = -x; x = keep;
      z = longint'(narrow_q62(PI_HALF_Q62));
    end
    for (int i = 0; i < F; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(arctan_steps[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(arctan_steps[i]);
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  function automatic distance_t predict_distance(logic signed [17:0] lat_a,
                                                 logic signed [18:0] lon_a,
                                                 logic signed [17:0] lat_b,
                                                 logic signed [18:0] lon_b);
    distance_t res;
    longint one, c1, s1, c2, s2, cd, sd, diff, cosine, ang;
    longint unsigned dist_m;
    bit flip;
    one = longint'(64'd1 << F);
    flip = 1'b0;
    if (lat_a < -LAT_LIMIT || lat_a > LAT_LIMIT || lat_b < -LAT_LIMIT || lat_b > LAT_LIMIT ||
        lon_a < -LON_LIMIT || lon_a > LON_LIMIT || lon_b < -LON_LIMIT || lon_b > LON_LIMIT)
    begin
      res.distance = '0;
      res.range_err = 1'b1;
      return res;
    end
    rotate_angle(to_rad(lat_a), c1, s1);
    rotate_angle(to_rad(lat_b), c2, s2);
    // fold the longitude gap into 0..90 deg, remembering a sign flip of cos
    diff = longint'(lon_b) - longint'(lon_a);
    if (diff < 0) diff = -diff;
    if (diff > LON_LIMIT) diff = 2 * LON_LIMIT - diff;
    if (diff > LAT_LIMIT) begin
      diff = LON_LIMIT - diff; flip = 1'b1;
    end
    rotate_angle(to_rad(diff), cd, sd);
    if (flip) cd = -cd;
    cosine = q_mul(s1, s2) + q_mul(q_mul(c1, c2), cd);
    if (cosine > one) cosine = one;
    if (cosine < -one) cosine = -one;
    ang = arc_cosine(cosine);
    dist_m = rnd_mul_shift(longint'(ang), 64'(RADIUS_M), F);
    if (dist_m > 64'(MAX_DISTANCE)) dist_m = 64'(MAX_DISTANCE);
    res.distance = dist_m[24:0];
    res.range_err = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One point-pair transfer; optional idle gap before it. Busy is sampled at
  // the falling edge so the accept decision is race free.
  task automatic send_pair(input logic signed [17:0] lat_a, input logic signed [18:0] lon_a,
                           input logic signed [17:0] lat_b, input logic signed [18:0] lon_b,
                           input int idle_pct);
    logic stalled;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start              <= 1'b1;
    first_latitude_i   <= lat_a;
    first_longitude_i  <= lon_a;
    second_latitude_i  <= lat_b;
    second_longitude_i <= lon_b;
    do begin
      @(negedge clk_i);
      stalled = busy;
      @(posedge clk_i);
    end while (stalled);
    pending_distances.push_back(predict_distance(lat_a, lon_a, lat_b, lon_b));
  endtask

  // Extremes, out-of-range coordinates, folds, saturation and zero distance.
  task automatic test_directed();
    send_pair(0, 0, 0, 0, 0);                          // same point
    send_pair(45123, -73456, 45123, -73456, 0);        // same point, off origin
    send_pair(90000, 0, -90000, 0, 0);                 // pole to pole, saturates
    send_pair(0, 0, 0, 180000, 0);                     // antipodes on equator
    send_pair(0, -180000, 0, 180000, 0);               // same meridian, both seams
    send_pair(10000, -170000, -10000, 170000, 0);      // gap folds past half turn
    send_pair(0, 0, 0, 90001, 0);                      // gap just over quarter: flip
    send_pair(0, 0, 0, 90000, 0);                      // gap exactly quarter
    send_pair(90000, 180000, 90000, -180000, 0);       // pole, extreme longitudes
    send_pair(-90000, -180000, 89999, 179999, 0);
    send_pair(0, 0, 0, 1, 0);                          // tiny distance
    send_pair(0, 0, 0, 179999, 0);                     // near antipodal
    send_pair(90001, 0, 0, 0, 0);                      // each field out of range
    send_pair(0, 0, -90001, 0, 0);
    send_pair(0, 180001, 0, 0, 0);
    send_pair(0, 0, 0, -180001, 0);
    send_pair(18'sh1FFFF, 19'sh3FFFF, 18'sh20000, 19'sh40000, 0);  // raw extremes
    send_pair(18'sh20000, 0, 0, 0, 0);
    send_pair(0, 19'sh40000, 0, 0, 0);
    send_pair(51477, -1, 40712, -74006, 0);
    start <= 1'b0;
  endtask

  // Mostly valid point pairs, some near-equal or near-antipodal, some raw noise.
  task automatic test_random(input int count, input int idle_pct);
    logic signed [17:0] lat_a, lat_b;
    logic signed [18:0] lon_a, lon_b;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      lat_a = 18'(int'($urandom_range(180000)) - 90000);
      lon_a = 19'(int'($urandom_range(360000)) - 180000);
      if (kind < 15) begin
        // close neighbors; an out-of-range coordinate falls back to the first point's
        lat_b = 18'(int'(lat_a) + int'($urandom_range(200)) - 100);
        lon_b = 19'(int'(lon_a) + int'($urandom_range(200)) - 100);
        if (lat_b > LAT_LIMIT || lat_b < -LAT_LIMIT) lat_b = lat_a;
        if (lon_b > LON_LIMIT || lon_b < -LON_LIMIT) lon_b = lon_a;
      end else if (kind < 25) begin
        // near the antipode
        lat_b = 18'(-int'(lat_a) + int'($urandom_range(20)) - 10);
        if (lat_b > LAT_LIMIT || lat_b < -LAT_LIMIT) lat_b = -lat_a;
        lon_b = 19'(lon_a > 0 ? int'(lon_a) - 180000 : int'(lon_a) + 180000);
      end else if (kind < 88) begin
        lat_b = 18'(int'($urandom_range(180000)) - 90000);
        lon_b = 19'(int'($urandom_range(360000)) - 180000);
      end else begin
        // raw bit patterns, mostly out of range
        lat_a = 18'($urandom);
        lon_a = 19'($urandom);
        lat_b = 18'($urandom);
        lon_b = 19'($urandom);
      end
      send_pair(lat_a, lon_a, lat_b, lon_b, idle_pct);
    end
    start <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: results last one cycle, sampled mid-cycle
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    distance_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_distances.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: distance=%0d err=%0b", distance_metres_o, range_error_o);
      end else begin
        want = pending_distances.pop_front();
        if (want.distance !== distance_metres_o || want.range_err !== range_error_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected distance=%0d err=%0b, got distance=%0d err=%0b",
                     want.distance, want.range_err, distance_metres_o, range_error_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    start              <= 1'b0;
    first_latitude_i   <= '0;
    first_longitude_i  <= '0;
    second_latitude_i  <= '0;
    second_longitude_i <= '0;
    for (int i = 0; i < F; i++) arctan_steps[i] = narrow_q62(arctan_pow2(i));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(RANDOM_ITEMS, 30);
    test_random(RANDOM_ITEMS, 75);
    test_random(RANDOM_ITEMS, 0);

    // drain the pipeline, then allow for strays
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
